// ----- rtl/dcd_pkg.sv -----
// ----------------------------------------------------------------------------
// Double clap detector package
// Shared types and constants for the window framing, evaluation and
// configuration logic.
// ----------------------------------------------------------------------------
package dcd_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned CountW  = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned PhaseW  = 8;

  // Window and gap lengths in milliseconds.
  localparam logic [PhaseW-1:0] WINDOW_MS = 8'd100;
  localparam logic [PhaseW-1:0] GAP_MS    = 8'd20;
  localparam logic [PhaseW-1:0] PHASE_MAX = 8'd255;

  localparam logic [CountW-1:0] COUNT_MAX = 16'hFFFF;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_LOUD_LEVEL     = 3'd0,
    REG_ACTIVE_COUNT   = 3'd1,
    REG_CLAP_COUNT_MIN = 3'd2,
    REG_CLAP_COUNT_MAX = 3'd3,
    REG_CROSSINGS_MIN  = 3'd4,
    REG_DURATION_MIN   = 3'd5,
    REG_DURATION_MAX   = 3'd6,
    REG_PAIR_WINDOW    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [SampleW-1:0] loud_level;
    logic [CountW-1:0]  active_count;
    logic [CountW-1:0]  clap_count_min;
    logic [CountW-1:0]  clap_count_max;
    logic [CountW-1:0]  crossings_min;
    logic [CountW-1:0]  duration_min;
    logic [CountW-1:0]  duration_max;
    logic [CountW-1:0]  pair_window;
  } cfg_t;

  // Window framing to evaluation: end-of-window event and its totals.
  typedef struct packed {
    logic              window_end;
    logic [CountW-1:0] loud_total;
    logic [CountW-1:0] crossing_total;
  } win_evt_t;

  // Evaluation results for one item.
  typedef struct packed {
    logic              lamp_on;
    logic              clap_seen;
    logic              pair_seen;
    logic              sound_on;
    logic [CountW-1:0] last_duration;
  } eval_res_t;

endpackage

// ----- rtl/dcd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the eight detection thresholds, written through a plain write port.
// ----------------------------------------------------------------------------
module dcd_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [dcd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [dcd_pkg::CfgDataW-1:0] cfg_data,
  output dcd_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.loud_level     <= 12'd4000;
      cfg.active_count   <= 16'd120;
      cfg.clap_count_min <= 16'd150;
      cfg.clap_count_max <= 16'd400;
      cfg.crossings_min  <= 16'd60;
      cfg.duration_min   <= 16'd30;
      cfg.duration_max   <= 16'd150;
      cfg.pair_window    <= 16'd800;
    end else if (cfg_we) begin
      unique case (dcd_pkg::cfg_reg_t'(cfg_index))
        dcd_pkg::REG_LOUD_LEVEL:     cfg.loud_level     <= cfg_data[dcd_pkg::SampleW-1:0];
        dcd_pkg::REG_ACTIVE_COUNT:   cfg.active_count   <= cfg_data;
        dcd_pkg::REG_CLAP_COUNT_MIN: cfg.clap_count_min <= cfg_data;
        dcd_pkg::REG_CLAP_COUNT_MAX: cfg.clap_count_max <= cfg_data;
        dcd_pkg::REG_CROSSINGS_MIN:  cfg.crossings_min  <= cfg_data;
        dcd_pkg::REG_DURATION_MIN:   cfg.duration_min   <= cfg_data;
        dcd_pkg::REG_DURATION_MAX:   cfg.duration_max   <= cfg_data;
        dcd_pkg::REG_PAIR_WINDOW:    cfg.pair_window    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/dcd_window.sv -----
// ----------------------------------------------------------------------------
// Window framing and counting
// Splits the sample stream into analysis windows and gaps, and counts loud
// samples, and the loud samples that cross mid-scale, inside each window.
// ----------------------------------------------------------------------------
module dcd_window (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [dcd_pkg::SampleW-1:0] sample,
  input  logic                        ms_tick,
  input  logic [dcd_pkg::SampleW-1:0] loud_level,
  output dcd_pkg::win_evt_t           evt
);

  logic                        in_window, in_window_next;
  logic                        have_prev, have_prev_next;
  logic [dcd_pkg::PhaseW-1:0]  phase, phase_next, phase_inc;
  logic [dcd_pkg::SampleW-1:0] prev_sample, prev_sample_next;
  logic [dcd_pkg::CountW-1:0]  loud_cnt, loud_cnt_next;
  logic [dcd_pkg::CountW-1:0]  cross_cnt, cross_cnt_next;
  logic                        is_loud, crossed;

  always_comb begin
    phase_inc = (ms_tick && phase != dcd_pkg::PHASE_MAX) ? phase + 8'd1 : phase;
    is_loud   = sample > loud_level;
    // The top bit of the sample tells which side of mid-scale it lies on.
    crossed   = sample[dcd_pkg::SampleW-1] != prev_sample[dcd_pkg::SampleW-1];

    in_window_next   = in_window;
    have_prev_next   = have_prev;
    phase_next       = phase_inc;
    prev_sample_next = prev_sample;
    loud_cnt_next    = loud_cnt;
    cross_cnt_next   = cross_cnt;
    evt              = '0;

    if ((in_window && !have_prev) || (!in_window && phase_inc >= dcd_pkg::GAP_MS)) begin
      // Seed a new window: this sample only sets the previous value.
      in_window_next   = 1'b1;
      have_prev_next   = 1'b1;
      phase_next       = '0;
      prev_sample_next = sample;
      loud_cnt_next    = '0;
      cross_cnt_next   = '0;
    end else if (in_window && phase_inc >= dcd_pkg::WINDOW_MS) begin
      evt.window_end     = 1'b1;
      evt.loud_total     = loud_cnt;
      evt.crossing_total = cross_cnt;
      in_window_next     = 1'b0;
      phase_next         = '0;
    end else if (in_window) begin
      prev_sample_next = sample;
      if (is_loud) begin
        if (loud_cnt != dcd_pkg::COUNT_MAX) loud_cnt_next = loud_cnt + 16'd1;
        if (crossed && cross_cnt != dcd_pkg::COUNT_MAX) cross_cnt_next = cross_cnt + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_window   <= 1'b1;
      have_prev   <= 1'b0;
      phase       <= '0;
      prev_sample <= '0;
      loud_cnt    <= '0;
      cross_cnt   <= '0;
    end else if (step) begin
      in_window   <= in_window_next;
      have_prev   <= have_prev_next;
      phase       <= phase_next;
      prev_sample <= prev_sample_next;
      loud_cnt    <= loud_cnt_next;
      cross_cnt   <= cross_cnt_next;
    end
  end

endmodule

// ----- rtl/dcd_eval.sv -----
// ----------------------------------------------------------------------------
// Window evaluation
// Keeps the millisecond clock, tracks active sounds, qualifies claps and
// pairs two claps into a lamp toggle.
// ----------------------------------------------------------------------------
module dcd_eval (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               ms_tick,
  input  dcd_pkg::win_evt_t  evt,
  input  dcd_pkg::cfg_t      cfg,
  output dcd_pkg::eval_res_t res
);

  logic [dcd_pkg::TimeW-1:0]  clock_ms, clock_next;
  logic [dcd_pkg::TimeW-1:0]  start_ms, start_next;
  logic [dcd_pkg::TimeW-1:0]  first_ms, first_next;
  logic [dcd_pkg::TimeW-1:0]  span, since_first, pair_win;
  logic [dcd_pkg::CountW-1:0] duration, duration_next;
  logic                       active, active_next;
  logic                       waiting, waiting_next;
  logic                       lamp, lamp_next;
  logic                       clap, pair;

  always_comb begin
    clock_next    = clock_ms + {31'd0, ms_tick};
    span          = clock_next - start_ms;
    since_first   = clock_next - first_ms;
    pair_win      = {16'd0, cfg.pair_window};
    start_next    = start_ms;
    first_next    = first_ms;
    duration_next = duration;
    active_next   = active;
    waiting_next  = waiting;
    lamp_next     = lamp;
    clap          = 1'b0;
    pair          = 1'b0;

    if (evt.window_end) begin
      if (evt.loud_total > cfg.active_count && !active) begin
        active_next = 1'b1;
        start_next  = clock_next;
      end
      if (evt.loud_total < cfg.active_count && active) begin
        active_next   = 1'b0;
        duration_next = (span[dcd_pkg::TimeW-1:dcd_pkg::CountW] != '0) ?
                        dcd_pkg::COUNT_MAX : span[dcd_pkg::CountW-1:0];
      end
      clap = evt.loud_total > cfg.clap_count_min && evt.loud_total < cfg.clap_count_max &&
             evt.crossing_total > cfg.crossings_min &&
             duration_next > cfg.duration_min && duration_next < cfg.duration_max;
      if (!waiting) begin
        if (clap) begin
          waiting_next = 1'b1;
          first_next   = clock_next;
        end
      end else begin
        pair = clap && since_first < pair_win;
        if (pair) lamp_next = !lamp;
        // A pair ends the wait, and so does a first clap that has gone stale.
        if (pair || since_first > pair_win) waiting_next = 1'b0;
      end
    end

    res.lamp_on       = lamp_next;
    res.clap_seen     = clap;
    res.pair_seen     = pair;
    res.sound_on      = active_next;
    res.last_duration = duration_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_ms <= '0;
      start_ms <= '0;
      first_ms <= '0;
      duration <= '0;
      active   <= 1'b0;
      waiting  <= 1'b0;
      lamp     <= 1'b0;
    end else if (step) begin
      clock_ms <= clock_next;
      start_ms <= start_next;
      first_ms <= first_next;
      duration <= duration_next;
      active   <= active_next;
      waiting  <= waiting_next;
      lamp     <= lamp_next;
    end
  end

endmodule

// ----- rtl/double_clap_detector_top.sv -----
// ----------------------------------------------------------------------------
// Double clap detector
// Streams microphone samples, detects two claps in quick succession and
// toggles a lamp level.
// ----------------------------------------------------------------------------
// Usage: each slave-side transaction carries one 12-bit converter sample and
// a flag saying one millisecond passed before it. Every accepted sample
// yields exactly one master-side transaction with the lamp level, the
// window-end, clap and pair flags, the totals of the evaluated window, the
// active-sound flag and the last sound duration.
// An accepted sample is loaded into the input register, and the framing and
// evaluation logic then run from it into the result register. Throughput is
// one transaction per cycle while the receiver keeps up; the state registers
// are updated in the same edge that loads the result register, so the next
// sample sees them at once.
// When the receiver stalls, the result register holds and an empty input
// register still takes one more sample; after that s_tready drops until the
// result is taken. Configuration writes take effect on the next clock and
// are meant to happen while no transaction is in flight.
// Reset (synchronous, active high) empties both registers, restores the
// default thresholds and clears the lamp, clocks, counters and trackers.
// ----------------------------------------------------------------------------
module double_clap_detector_top (
  input  logic                         clk,
  input  logic                         rst,
  // Sample stream.
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [15:0]                  s_tdata,   // [11:0] sample, [12] ms_tick
  // Result stream.
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [0] lamp_on, [1] window_end, [2] clap_seen, [3] pair_seen,
  // [19:4] loud_total, [35:20] crossing_total, [36] sound_on,
  // [52:37] last_duration
  output logic [55:0]                  m_tdata,
  // Configuration write port.
  input  logic                         cfg_we,
  input  logic [dcd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [dcd_pkg::CfgDataW-1:0] cfg_data
);

  logic                        in_valid;
  logic [dcd_pkg::SampleW-1:0] in_sample;
  logic                        in_tick;
  logic                        step;
  dcd_pkg::cfg_t               cfg;
  dcd_pkg::win_evt_t           evt;
  dcd_pkg::eval_res_t          res;

  // The held sample moves on whenever the result register is free or drains.
  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= s_tdata[dcd_pkg::SampleW-1:0];
      in_tick   <= s_tdata[dcd_pkg::SampleW];
    end
  end

  dcd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dcd_window u_window (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .sample     (in_sample),
    .ms_tick    (in_tick),
    .loud_level (cfg.loud_level),
    .evt        (evt)
  );

  dcd_eval u_eval (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .ms_tick (in_tick),
    .evt     (evt),
    .cfg     (cfg),
    .res     (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {3'd0, res.last_duration, res.sound_on, evt.crossing_total,
                  evt.loud_total, res.pair_seen, res.clap_seen, evt.window_end,
                  res.lamp_on};
    end
  end

endmodule

// ----- tb/tb_double_clap_detector_top.sv -----
// ----------------------------------------------------------------------------
// Double clap detector testbench
// Streams microphone samples through the detector and checks every result
// transaction against a cycle-free behavioral model of the window framing,
// loud and crossing counters, sound tracker, clap qualifier and lamp pairing.
// Stimulus runs through default, clap-friendly, random, all-zero and all-one
// register settings, with random idling on both stream sides and one long
// receiver hold.
// ----------------------------------------------------------------------------
module tb_double_clap_detector_top;
  import dcd_pkg::*;

  localparam int unsigned CycleLimit = 6000000;
  localparam int unsigned LongHold   = 300;
  localparam logic [SampleW-1:0] MidScale = 12'h800;

  // One input item, packed as it travels in s_tdata.
  typedef struct packed {
    logic               tick;
    logic [SampleW-1:0] smp;
  } mic_item_t;

  // One result, laid out as m_tdata (last field in the lowest bits).
  typedef struct packed {
    logic [2:0]        pad;
    logic [CountW-1:0] last_duration;
    logic              sound_on;
    logic [CountW-1:0] crossing_total;
    logic [CountW-1:0] loud_total;
    logic              pair_seen;
    logic              clap_seen;
    logic              window_end;
    logic              lamp_on;
  } report_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [15:0]         s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [55:0]         m_tdata;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  double_clap_detector_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Model copy of the configuration registers, starting at their reset values.
  cfg_t model_cfg = '{loud_level: 12'd4000, active_count: 16'd120, clap_count_min: 16'd150,
                      clap_count_max: 16'd400, crossings_min: 16'd60, duration_min: 16'd30,
                      duration_max: 16'd150, pair_window: 16'd800};

  // Model copy of the detector state.
  logic              in_window = 1'b1;
  logic [PhaseW-1:0] ms_phase = '0;
  logic              seeded = 1'b0;
  logic [SampleW-1:0] prev_smp = '0;
  logic [CountW-1:0] loud_cnt = '0;
  logic [CountW-1:0] cross_cnt = '0;
  logic              snd_active = 1'b0;
  logic [TimeW-1:0]  snd_start = '0;
  logic [CountW-1:0] snd_len = '0;
  logic [TimeW-1:0]  now_ms = '0;
  logic              await_second = 1'b0;
  logic [TimeW-1:0]  first_clap_at = '0;
  logic              lamp = 1'b0;

  mic_item_t mic_samples[$];
  report_t   detector_reports[$];
  mic_item_t next_item;

  int  mismatches = 0;
  int  results_seen = 0;
  int  n_windows = 0;
  int  n_claps = 0;
  int  n_pairs = 0;
  int  cycle_count = 0;
  int  hold_ask = 0;
  int  hold_done = 0;
  int  send_gap = 0;
  int  recv_gap = 0;

  // Stimulus-side copy of the window framing, which depends on ticks only.
  bit  gen_started = 1'b0;
  bit  gen_in_win = 1'b1;
  int  gen_ms = 0;

  function automatic void open_window(logic [SampleW-1:0] smp);
    in_window = 1'b1;
    ms_phase  = '0;
    seeded    = 1'b1;
    prev_smp  = smp;
    loud_cnt  = '0;
    cross_cnt = '0;
  endfunction

  // Advances the model by one accepted sample and returns the result it causes.
  function automatic report_t detect_step(logic [SampleW-1:0] smp, logic tick);
    report_t r;
    logic [TimeW-1:0] elapsed;
    r = '0;
    if (tick) now_ms = now_ms + 32'd1;
    if (in_window) begin
      if (!seeded) begin
        open_window(smp);
      end else begin
        if (tick && ms_phase < PHASE_MAX) ms_phase = ms_phase + 8'd1;
        if (ms_phase >= WINDOW_MS) begin
          r.window_end     = 1'b1;
          r.loud_total     = loud_cnt;
          r.crossing_total = cross_cnt;
          if (loud_cnt > model_cfg.active_count && !snd_active) begin
            snd_active = 1'b1;
            snd_start  = now_ms;
          end
          // A count equal to the threshold leaves the sound flag alone.
          if (loud_cnt < model_cfg.active_count && snd_active) begin
            elapsed    = now_ms - snd_start;
            snd_active = 1'b0;
            snd_len    = (elapsed > COUNT_MAX) ? COUNT_MAX : elapsed[CountW-1:0];
          end
          r.clap_seen = loud_cnt > model_cfg.clap_count_min &&
                        loud_cnt < model_cfg.clap_count_max &&
                        cross_cnt > model_cfg.crossings_min &&
                        snd_len > model_cfg.duration_min &&
                        snd_len < model_cfg.duration_max;
          if (r.clap_seen) begin
            if (!await_second) begin
              await_second  = 1'b1;
              first_clap_at = now_ms;
            end else if ((now_ms - first_clap_at) < model_cfg.pair_window) begin
              await_second = 1'b0;
              lamp         = ~lamp;
              r.pair_seen  = 1'b1;
            end
          end
          // A late second clap is ignored; the wait simply times out.
          if (await_second && (now_ms - first_clap_at) > model_cfg.pair_window)
            await_second = 1'b0;
          in_window = 1'b0;
          ms_phase  = '0;
        end else begin
          if (smp > model_cfg.loud_level) begin
            if (loud_cnt != COUNT_MAX) loud_cnt = loud_cnt + 16'd1;
            if ((smp >= MidScale) != (prev_smp >= MidScale) && cross_cnt != COUNT_MAX)
              cross_cnt = cross_cnt + 16'd1;
          end
          prev_smp = smp;
        end
      end
    end else begin
      if (tick && ms_phase < PHASE_MAX) ms_phase = ms_phase + 8'd1;
      if (ms_phase >= GAP_MS) open_window(smp);
    end
    r.lamp_on       = lamp;
    r.sound_on      = snd_active;
    r.last_duration = snd_len;
    n_windows += int'(r.window_end);
    n_claps   += int'(r.clap_seen);
    n_pairs   += int'(r.pair_seen);
    return r;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic push_item(logic [SampleW-1:0] s, logic t);
    mic_item_t it;
    it.smp  = s;
    it.tick = t;
    mic_samples.push_back(it);
    if (!gen_started) begin
      gen_started = 1'b1;
      gen_in_win  = 1'b1;
      gen_ms      = 0;
    end else begin
      if (t) gen_ms++;
      if (gen_in_win && gen_ms >= WINDOW_MS) begin
        gen_in_win = 1'b0;
        gen_ms     = 0;
      end else if (!gen_in_win && gen_ms >= GAP_MS) begin
        gen_in_win = 1'b1;
        gen_ms     = 0;
      end
    end
  endtask

  // Finishes the current window and the gap after it. A non-negative
  // loud_n places exactly that many loud samples, each right after a quiet
  // sample below mid-scale so that each also crosses; ticks are spread so the
  // pattern fits in the window. A negative loud_n gives random noise.
  task automatic push_cycle(int loud_n);
    int span, i, lvl, noise_p;
    logic [SampleW-1:0] s;
    logic t;
    lvl     = int'(model_cfg.loud_level);
    span    = ((2 * loud_n + 1 > 100) ? 2 * loud_n + 1 : 100) + $urandom_range(0, 20);
    noise_p = $urandom_range(25, 100);
    i = 0;
    while (gen_in_win) begin
      if (loud_n < 0) begin
        s = 12'($urandom_range(0, 4095));
        t = $urandom_range(1, 100) <= noise_p;
      end else begin
        if (i < 2 * loud_n && lvl < 4095) begin
          if (i % 2 == 1) s = 12'($urandom_range((lvl + 1 > 2048) ? lvl + 1 : 2048, 4095));
          else s = 12'($urandom_range(0, (lvl < 2047) ? lvl : 2047));
        end else begin
          s = 12'($urandom_range(0, lvl));
        end
        t = (i >= span) || (((i + 1) * 99 / span) != (i * 99 / span));
      end
      push_item(s, t);
      i++;
    end
    while (!gen_in_win) push_item(12'($urandom_range(0, 4095)), $urandom_range(0, 3) != 0);
  endtask

  // Loud count for the next window: clap range, quiet, a threshold edge,
  // or noise.
  function automatic int pick_loud();
    int r, lo, hi;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      lo = int'(model_cfg.clap_count_min) + 1;
      hi = int'(model_cfg.clap_count_max) - 1;
    end else if (r < 70) begin
      lo = 0;
      hi = int'(model_cfg.active_count) - 1;
    end else if (r < 85) begin
      case ($urandom_range(0, 4))
        0: lo = int'(model_cfg.active_count);
        1: lo = int'(model_cfg.clap_count_min);
        2: lo = int'(model_cfg.clap_count_min) + 1;
        3: lo = int'(model_cfg.clap_count_max);
        default: lo = int'(model_cfg.clap_count_max) - 1;
      endcase
      hi = lo;
    end else begin
      return -1;
    end
    if (hi > 400) hi = 400;
    if (hi < 0) hi = 0;
    if (lo > hi) lo = hi;
    if (lo < 0) lo = 0;
    return $urandom_range(lo, hi);
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_LOUD_LEVEL:     model_cfg.loud_level     = val[SampleW-1:0];
      REG_ACTIVE_COUNT:   model_cfg.active_count   = val;
      REG_CLAP_COUNT_MIN: model_cfg.clap_count_min = val;
      REG_CLAP_COUNT_MAX: model_cfg.clap_count_max = val;
      REG_CROSSINGS_MIN:  model_cfg.crossings_min  = val;
      REG_DURATION_MIN:   model_cfg.duration_min   = val;
      REG_DURATION_MAX:   model_cfg.duration_max   = val;
      default:            model_cfg.pair_window    = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_regs(logic [15:0] loud, act, cmin, cmax, xmin, dmin, dmax, pwin);
    write_reg(REG_LOUD_LEVEL, loud);
    write_reg(REG_ACTIVE_COUNT, act);
    write_reg(REG_CLAP_COUNT_MIN, cmin);
    write_reg(REG_CLAP_COUNT_MAX, cmax);
    write_reg(REG_CROSSINGS_MIN, xmin);
    write_reg(REG_DURATION_MIN, dmin);
    write_reg(REG_DURATION_MAX, dmax);
    write_reg(REG_PAIR_WINDOW, pwin);
  endtask

  // Waits until every queued sample is sent and every predicted result has been
  // taken, then waits out the pipeline.
  task automatic drain();
    while (mic_samples.size() != 0 || s_tvalid || detector_reports.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Sender: offers queued samples with random gaps and predicts each accepted one.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        detector_reports.push_back(detect_step(s_tdata[SampleW-1:0], s_tdata[SampleW]));
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (mic_samples.size() != 0) begin
          next_item = mic_samples.pop_front();
          s_tdata  <= {3'b000, next_item};
          s_tvalid <= 1'b1;
          send_gap = draw_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, a long hold on request, and the check of
  // every result transaction against the oldest prediction.
  always @(posedge clk) begin
    report_t want, got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        got = report_t'(m_tdata);
        if (detector_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
          mismatches++;
        end else begin
          want = detector_reports.pop_front();
          compare_field("lamp_on", 16'(want.lamp_on), 16'(got.lamp_on));
          compare_field("window_end", 16'(want.window_end), 16'(got.window_end));
          compare_field("clap_seen", 16'(want.clap_seen), 16'(got.clap_seen));
          compare_field("pair_seen", 16'(want.pair_seen), 16'(got.pair_seen));
          compare_field("loud_total", want.loud_total, got.loud_total);
          compare_field("crossing_total", want.crossing_total, got.crossing_total);
          compare_field("sound_on", 16'(want.sound_on), 16'(got.sound_on));
          compare_field("last_duration", want.last_duration, got.last_duration);
          compare_field("padding", 16'(want.pad), 16'(got.pad));
        end
      end
      if (hold_ask != hold_done) begin
        hold_done = hold_ask;
        recv_gap  = LongHold;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (m_tvalid && m_tready) recv_gap = draw_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, detector_reports.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed samples in the first window: the seed, the sample extremes,
    // both sides of mid-scale and of the default loud level, with and
    // without ticks.
    push_item(12'd0, 1'b1);
    push_item(12'd4095, 1'b1);
    push_item(12'd0, 1'b0);
    push_item(12'd4095, 1'b0);
    push_item(12'd2047, 1'b1);
    push_item(12'd2048, 1'b1);
    push_item(12'd4000, 1'b0);
    push_item(12'd4001, 1'b1);
    push_item(12'd4001, 1'b0);
    push_item(12'd100, 1'b1);
    push_item(12'd4095, 1'b1);
    push_item(12'd2048, 1'b0);
    push_item(12'd1, 1'b0);
    push_item(12'd4094, 1'b1);
    push_cycle(0);
    drain();

    // Clap-friendly thresholds: a clean double clap, then a random window
    // during a long receiver hold while the sender keeps offering.
    program_regs(16'd3000, 16'd15, 16'd20, 16'd80, 16'd10, 16'd30, 16'd150, 16'd800);
    push_cycle(50);
    push_cycle(0);
    push_cycle(50);
    push_cycle(0);
    push_cycle(50);
    hold_ask++;
    push_cycle(pick_loud());
    drain();

    // Random thresholds around the same shape.
    program_regs(16'($urandom_range(2048, 4094)), 16'($urandom_range(5, 30)),
                 16'($urandom_range(20, 50)), 16'($urandom_range(55, 110)),
                 16'($urandom_range(0, 20)), 16'($urandom_range(0, 130)),
                 16'($urandom_range(100, 300)), 16'($urandom_range(100, 1000)));
    repeat (2) push_cycle(pick_loud());
    drain();

    // All registers at zero, then all ones (the loud level masks to 12 bits).
    program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                 16'h0000);
    push_cycle(pick_loud());
    drain();
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF);
    push_cycle(0);
    drain();
    repeat (20) @(negedge clk);

    $display("Checked %0d results: %0d window ends, %0d claps, %0d lamp toggles.",
             results_seen, n_windows, n_claps, n_pairs);
    $display("Threshold sets: defaults, clap-friendly with a long hold, random, zeros, ones.");
    if (mismatches == 0 && detector_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dcd_pkg.sv
rtl/dcd_cfg_regs.sv
rtl/dcd_window.sv
rtl/dcd_eval.sv
rtl/double_clap_detector_top.sv
tb/tb_double_clap_detector_top.sv
